// ----- rtl/fpv_pkg.sv -----
// Package for the plurality vote block: widths, register indexes and queue entry type.
// No dependencies.
`default_nettype none
package fpv_pkg;
  localparam int NCAT     = 16;
  localparam int CAT_W    = 4;
  localparam int CNT_W    = 10;
  localparam int JIT_W    = 16;
  localparam int SUM_W    = JIT_W + 10;
  localparam int NCFG_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CNT_W-1:0] MAX_TREES = 10'd1023;
  localparam logic [CFG_IDX_W-1:0] REG_N_CATEGORIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_CATEGORY = 1'b1;

  // One classified tree beat as it waits in the queue.
  typedef struct packed {
    logic             vote;     // counts towards a category
    logic             scored;   // counts towards voting trees
    logic [CAT_W-1:0] category;
    logic [JIT_W-1:0] jitter;
    logic             last;
  } fpv_entry_t;
endpackage
`default_nettype wire

// ----- rtl/fpv_if.sv -----
// Valid/ready channel interfaces for the plurality vote block.
// Depends on fpv_pkg.
`default_nettype none
interface fpv_in_if;
  logic                      valid;
  logic                      ready;
  logic                      has_score;
  logic [fpv_pkg::CAT_W-1:0] category;
  logic [fpv_pkg::JIT_W-1:0] jitter;
  logic                      last_tree;
  modport source (output valid, has_score, category, jitter, last_tree, input ready);
  modport sink (input valid, has_score, category, jitter, last_tree, output ready);
endinterface

interface fpv_out_if;
  logic                      valid;
  logic                      ready;
  logic [fpv_pkg::CAT_W-1:0] winner;
  logic [fpv_pkg::CNT_W-1:0] winner_votes;
  logic [fpv_pkg::CNT_W-1:0] voting_trees;
  modport source (output valid, winner, winner_votes, voting_trees, input ready);
  modport sink (input valid, winner, winner_votes, voting_trees, output ready);
endinterface

interface fpv_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpv_pkg::CFG_IDX_W-1:0]  index;
  logic [fpv_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/fpv_front.sv -----
// Front end: accepts tree beats, classifies them, and queues them in a two-entry FIFO.
// Depends on fpv_pkg.
`default_nettype none
module fpv_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_has_score,
  input  wire logic [fpv_pkg::CAT_W-1:0]  in_category,
  input  wire logic [fpv_pkg::JIT_W-1:0]  in_jitter,
  input  wire logic                       in_last_tree,
  input  wire logic [fpv_pkg::NCFG_W-1:0] n_categories,
  output logic                            q_valid,
  output fpv_pkg::fpv_entry_t             q_entry,
  input  wire logic                       q_pop
);
  fpv_pkg::fpv_entry_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  fpv_pkg::fpv_entry_t cls;
  logic push;

  // Classify: only categories below the configured count take a vote.
  always_comb begin
    cls.scored   = in_has_score;
    cls.vote     = in_has_score &&
                   ({1'b0, in_category} < n_categories);
    cls.category = in_category;
    cls.jitter   = in_jitter;
    cls.last     = in_last_tree;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_entry  = mem_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/fpv_back.sv -----
// Back end: accumulates votes and jitter, then scans categories on the last beat.
// Depends on fpv_pkg.
`default_nettype none
module fpv_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire fpv_pkg::fpv_entry_t        q_entry,
  output logic                            q_pop,
  input  wire logic [fpv_pkg::NCFG_W-1:0] n_categories,
  input  wire logic [fpv_pkg::CAT_W-1:0]  default_category,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [fpv_pkg::CAT_W-1:0]       out_winner,
  output logic [fpv_pkg::CNT_W-1:0]       out_winner_votes,
  output logic [fpv_pkg::CNT_W-1:0]       out_voting_trees
);
  localparam logic [1:0] ST_ACC = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CLR = 2'd2;

  logic [1:0] state_r;
  logic [fpv_pkg::CNT_W-1:0] votes_r [fpv_pkg::NCAT];
  logic [fpv_pkg::SUM_W-1:0] sums_r [fpv_pkg::NCAT];
  logic [fpv_pkg::CNT_W-1:0] trees_r;
  logic [fpv_pkg::CAT_W:0]   idx_r;
  logic [fpv_pkg::CAT_W-1:0] best_r;
  logic [fpv_pkg::CNT_W-1:0] best_cnt_r;
  logic [fpv_pkg::SUM_W-1:0] best_sum_r;
  logic [fpv_pkg::SUM_W:0]   sum_add;
  logic [fpv_pkg::CNT_W-1:0] cur_cnt;
  logic [fpv_pkg::SUM_W-1:0] cur_sum;
  logic                      better, scan_end;
  logic [fpv_pkg::CAT_W-1:0] cat;

  assign cat     = q_entry.category;
  assign q_pop   = (state_r == ST_ACC) && q_valid;
  assign sum_add = {1'b0, sums_r[cat]} + {{(fpv_pkg::SUM_W-fpv_pkg::JIT_W+1){1'b0}},
                                          q_entry.jitter};
  assign cur_cnt = votes_r[idx_r[fpv_pkg::CAT_W-1:0]];
  assign cur_sum = sums_r[idx_r[fpv_pkg::CAT_W-1:0]];
  assign better  = (cur_cnt != '0) &&
                   ((cur_cnt > best_cnt_r) ||
                    ((cur_cnt == best_cnt_r) && (cur_sum > best_sum_r)));
  assign scan_end = (idx_r == 5'd16) || (idx_r >= n_categories);

  // Sequencer: accumulate, scan one category per cycle, publish and clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_ACC;
      out_valid <= 1'b0;
      trees_r   <= '0;
      idx_r     <= '0;
      for (int i = 0; i < fpv_pkg::NCAT; i++) begin
        votes_r[i] <= '0;
        sums_r[i]  <= '0;
      end
    end else begin
      unique case (state_r)
        ST_ACC: begin
          if (q_pop) begin
            if (q_entry.vote) begin
              if (votes_r[cat] != fpv_pkg::MAX_TREES) votes_r[cat] <= votes_r[cat] + 1'b1;
              sums_r[cat] <= sum_add[fpv_pkg::SUM_W] ? '1 : sum_add[fpv_pkg::SUM_W-1:0];
            end
            if (q_entry.scored && trees_r != fpv_pkg::MAX_TREES) trees_r <= trees_r + 1'b1;
            if (q_entry.last) begin
              state_r    <= ST_SCAN;
              idx_r      <= '0;
              best_r     <= '0;
              best_cnt_r <= '0;
              best_sum_r <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            if (!out_valid) begin
              out_valid        <= 1'b1;
              out_winner       <= (best_cnt_r == '0) ? default_category : best_r;
              out_winner_votes <= (best_cnt_r == '0) ? 10'd1 : best_cnt_r;
              out_voting_trees <= trees_r;
              state_r          <= ST_CLR;
            end
          end else begin
            if (better) begin
              best_r     <= idx_r[fpv_pkg::CAT_W-1:0];
              best_cnt_r <= cur_cnt;
              best_sum_r <= cur_sum;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_CLR: begin
          for (int i = 0; i < fpv_pkg::NCAT; i++) begin
            votes_r[i] <= '0;
            sums_r[i]  <= '0;
          end
          trees_r <= '0;
          state_r <= ST_ACC;
        end
        default: state_r <= ST_ACC;
      endcase
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/forest_plurality_vote_jitter_tiebreak.sv -----
// Plurality vote over a tree ensemble with jitter tie-break. A tree beat is taken
// every cycle into a two-deep queue, unless the queue is full while the back end scans
// or clears; on the last beat the back end scans the categories in use, one per
// cycle, then clears its tallies. The result sits in an output register, so the
// next observation's beats are accepted while it waits. Depends on fpv_pkg and the
// channel interfaces.
`default_nettype none
module forest_plurality_vote_jitter_tiebreak (
  input wire logic   clk,
  input wire logic   rst_n,
  fpv_in_if.sink     in_ch,
  fpv_out_if.source  out_ch,
  fpv_cfg_if.sink    cfg_ch
);
  logic [fpv_pkg::NCFG_W-1:0] n_categories_r;
  logic [fpv_pkg::CAT_W-1:0]  default_category_r;
  logic                       q_valid, q_pop;
  fpv_pkg::fpv_entry_t        q_entry;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_categories_r     <= 5'd2;
      default_category_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        fpv_pkg::REG_N_CATEGORIES:     n_categories_r <= cfg_ch.data;
        fpv_pkg::REG_DEFAULT_CATEGORY: default_category_r <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  fpv_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_has_score(in_ch.has_score), .in_category(in_ch.category),
    .in_jitter(in_ch.jitter), .in_last_tree(in_ch.last_tree),
    .n_categories(n_categories_r),
    .q_valid, .q_entry, .q_pop
  );

  fpv_back u_back (
    .clk, .rst_n, .q_valid, .q_entry, .q_pop,
    .n_categories(n_categories_r), .default_category(default_category_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_winner(out_ch.winner), .out_winner_votes(out_ch.winner_votes),
    .out_voting_trees(out_ch.voting_trees)
  );

  // A published result always carries at least one vote.
  a_votes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.winner_votes != '0) else $error("zero winner votes");
  // The winner never has more votes than there were voting trees, unless there were no voting trees.
  a_votes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.voting_trees != '0) |-> out_ch.winner_votes <= out_ch.voting_trees)
    else $error("winner votes exceed voting trees");
  // The queue is popped only when it holds an entry.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ----- verif/fpv_vote_checker.sv -----
// Checker for the plurality vote block: watches the three channels, predicts each
// observation's verdict and compares it with the result beats. Depends on fpv_pkg and fpv_if.
`default_nettype none
module fpv_vote_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  fpv_in_if         in_mon,
  fpv_out_if        out_mon,
  fpv_cfg_if        cfg_mon,
  output int        verdicts_pending,
  output int        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [fpv_pkg::CAT_W-1:0] winner;
    logic [fpv_pkg::CNT_W-1:0] winner_votes;
    logic [fpv_pkg::CNT_W-1:0] voting_trees;
  } verdict_t;

  localparam logic [fpv_pkg::SUM_W-1:0] SUM_FULL = '1;

  // Shadow of the tally tables and the configuration.
  logic [fpv_pkg::CNT_W-1:0]  tally [fpv_pkg::NCAT];
  logic [fpv_pkg::SUM_W-1:0]  jit_total [fpv_pkg::NCAT];
  logic [fpv_pkg::CNT_W-1:0]  scorers;
  logic [fpv_pkg::NCFG_W-1:0] cat_limit;
  logic [fpv_pkg::CAT_W-1:0]  fallback_cat;
  verdict_t                   verdict_q [$];

  assign verdicts_pending = verdict_q.size();

  function automatic void clear_tally();
    for (int c = 0; c < fpv_pkg::NCAT; c++) begin
      tally[c] = '0;
      jit_total[c] = '0;
    end
    scorers = '0;
  endfunction

  // Count one tree beat and, on the last one, queue the verdict.
  function automatic void count_tree(logic has, logic [fpv_pkg::CAT_W-1:0] cat,
                                     logic [fpv_pkg::JIT_W-1:0] jit, logic last);
    verdict_t v;
    logic [fpv_pkg::SUM_W:0] grown;
    int best;
    logic [fpv_pkg::CNT_W-1:0] best_cnt;
    logic [fpv_pkg::SUM_W-1:0] best_sum;
    if (has) begin
      if (scorers < fpv_pkg::MAX_TREES) scorers++;
      if (cat < cat_limit) begin
        if (tally[cat] < fpv_pkg::MAX_TREES) tally[cat]++;
        grown = {1'b0, jit_total[cat]} + jit;
        jit_total[cat] = grown[fpv_pkg::SUM_W] ? SUM_FULL : grown[fpv_pkg::SUM_W-1:0];
      end
    end
    if (!last) return;
    best = 0;
    best_cnt = '0;
    best_sum = '0;
    for (int c = 0; c < fpv_pkg::NCAT && c < cat_limit; c++) begin
      if (tally[c] != 0 && (tally[c] > best_cnt ||
          (tally[c] == best_cnt && jit_total[c] > best_sum))) begin
        best = c;
        best_cnt = tally[c];
        best_sum = jit_total[c];
      end
    end
    if (best_cnt == 0) begin
      // Nobody voted for a category in use: fall back with a single vote.
      v.winner = fallback_cat;
      v.winner_votes = 10'd1;
    end else begin
      v.winner = best[fpv_pkg::CAT_W-1:0];
      v.winner_votes = best_cnt;
    end
    v.voting_trees = scorers;
    verdict_q.push_back(v);
    clear_tally();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cat_limit = 5'd2;
      fallback_cat = '0;
      clear_tally();
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == fpv_pkg::REG_N_CATEGORIES) cat_limit = cfg_mon.data;
        else if (cfg_mon.index == fpv_pkg::REG_DEFAULT_CATEGORY)
          fallback_cat = cfg_mon.data[fpv_pkg::CAT_W-1:0];
      end
      if (in_mon.valid && in_mon.ready)
        count_tree(in_mon.has_score, in_mon.category, in_mon.jitter, in_mon.last_tree);
      // Result beats are compared with the oldest verdict.
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no verdict waiting");
          fail_count++;
        end else begin
          verdict_t e;
          e = verdict_q.pop_front();
          if (out_mon.winner !== e.winner) begin
            $error("winner: expected %0d, got %0d", e.winner, out_mon.winner);
            fail_count++;
          end
          if (out_mon.winner_votes !== e.winner_votes) begin
            $error("winner_votes: expected %0d, got %0d", e.winner_votes, out_mon.winner_votes);
            fail_count++;
          end
          if (out_mon.voting_trees !== e.voting_trees) begin
            $error("voting_trees: expected %0d, got %0d", e.voting_trees, out_mon.voting_trees);
            fail_count++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- verif/forest_plurality_vote_jitter_tiebreak_tb.sv -----
// Top of the plurality vote testbench: clock, reset, tree and register stimulus,
// result stalls and the verdict. Depends on fpv_pkg, fpv_if and fpv_vote_checker.
`default_nettype none
module forest_plurality_vote_jitter_tiebreak_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_TREES = 110;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   verdicts_pending;
  int   fail_count;
  int   idle_cycles;
  int   trees_sent;
  int   cur_ncat;
  bit   no_gaps;
  bit   hold_req;
  bit   hold_taken;

  fpv_in_if  in_ch();
  fpv_out_if out_ch();
  fpv_cfg_if cfg_ch();

  forest_plurality_vote_jitter_tiebreak dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  fpv_vote_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .verdicts_pending(verdicts_pending), .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side: random stalls per beat, and one long hold when asked.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Offer one tree beat and wait for it to be taken.
  task automatic send_tree(logic has, logic [fpv_pkg::CAT_W-1:0] cat,
                           logic [fpv_pkg::JIT_W-1:0] jit, logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.has_score <= has;
    in_ch.category <= cat;
    in_ch.jitter <= jit;
    in_ch.last_tree <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    trees_sent++;
  endtask

  // Register write, only once every verdict is out and the scan has had time to end.
  task automatic write_reg(logic [fpv_pkg::CFG_IDX_W-1:0] idx,
                           logic [fpv_pkg::CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == fpv_pkg::REG_N_CATEGORIES) cur_ncat = val;
  endtask

  // One observation with random content, leaning on few categories so ties happen.
  task automatic random_observation(int len);
    for (int t = 0; t < len; t++) begin
      logic [fpv_pkg::CAT_W-1:0] cat;
      logic [fpv_pkg::JIT_W-1:0] jit;
      int in_use;
      in_use = (cur_ncat > 16) ? 16 : cur_ncat;
      if (in_use > 0 && $urandom_range(0, 9) < 7)
        cat = 4'($urandom_range(0, (in_use > 4 ? 4 : in_use) - 1) +
                 $urandom_range(0, in_use - 1) % in_use);
      else
        cat = 4'($urandom_range(0, 15));
      if (cat >= in_use && in_use > 0 && $urandom_range(0, 1)) cat = 4'(cat % in_use);
      case ($urandom_range(0, 3))
        0: jit = '0;
        1: jit = '1;
        2: jit = 16'($urandom_range(0, 3));
        default: jit = 16'($urandom_range(0, 65535));
      endcase
      send_tree($urandom_range(0, 9) != 0, cat, jit, t == len - 1);
    end
  endtask

  initial begin
    int ncat_set [8] = '{1, 16, 0, 31, 17, 3, 5, 2};
    int dflt_set [8] = '{15, 5, 3, 7, 0, 9, 12, 0};
    in_ch.valid = 1'b0;
    in_ch.has_score = 1'b0;
    in_ch.category = '0;
    in_ch.jitter = '0;
    in_ch.last_tree = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    idle_cycles = 0;
    trees_sent = 0;
    cur_ncat = 2;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    hold_taken = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part with the reset settings (two categories, default zero).
    send_tree(1'b0, 4'd3, 16'hFFFF, 1'b1);             // no vote at all
    send_tree(1'b1, 4'd0, 16'd100, 1'b0);              // equal votes, larger jitter wins
    send_tree(1'b1, 4'd1, 16'd200, 1'b1);
    send_tree(1'b1, 4'd1, 16'd5, 1'b0);                // full tie goes to the lower index
    send_tree(1'b1, 4'd0, 16'd5, 1'b1);
    send_tree(1'b1, 4'd7, 16'hFFFF, 1'b0);             // dropped categories still count as trees
    send_tree(1'b1, 4'd15, 16'hFFFF, 1'b1);
    send_tree(1'b1, 4'd1, 16'h0000, 1'b0);             // more votes beat larger jitter
    send_tree(1'b1, 4'd1, 16'h0000, 1'b0);
    send_tree(1'b1, 4'd0, 16'hFFFF, 1'b0);
    send_tree(1'b0, 4'd0, 16'hFFFF, 1'b1);
    send_tree(1'b1, 4'd1, 16'hAAAA, 1'b1);
    send_tree(1'b1, 4'd0, 16'h5555, 1'b1);

    // Default outside the categories in use, then zero categories drop everything.
    write_reg(fpv_pkg::REG_DEFAULT_CATEGORY, 5'd15);
    send_tree(1'b0, 4'd0, 16'd0, 1'b1);
    write_reg(fpv_pkg::REG_N_CATEGORIES, 5'd0);
    send_tree(1'b1, 4'd0, 16'hFFFF, 1'b0);
    send_tree(1'b1, 4'd15, 16'hFFFF, 1'b1);

    // Saturation of votes, jitter sums and tree count in one long observation.
    write_reg(fpv_pkg::REG_N_CATEGORIES, 5'd16);
    no_gaps = 1'b1;
    for (int t = 0; t < 1100; t++) send_tree(1'b1, 4'd15, 16'hFFFF, t == 1099);
    no_gaps = 1'b0;

    // Long result hold while single-tree observations keep arriving.
    hold_req = 1'b1;
    no_gaps = 1'b1;
    for (int k = 0; k < 24; k++) random_observation(1);
    no_gaps = 1'b0;
    in_ch.valid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);

    // Random phases over a range of settings, extremes included.
    trees_sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(fpv_pkg::REG_N_CATEGORIES, 5'(ncat_set[ph]));
      write_reg(fpv_pkg::REG_DEFAULT_CATEGORY, {1'($urandom_range(0, 1)), 4'(dflt_set[ph])});
      while (trees_sent < (ph + 1) * PHASE_TREES) begin
        if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
        random_observation($urandom_range(0, 7) == 0 ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8));
      end
    end
    no_gaps = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain and settle, then give the verdict.
    while (verdicts_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
